FILE: rtl/mavs_pkg.sv
// Package for the moving average with stability block.
// Holds widths, register and operation codes, reset values and the divider status type.
// No dependencies; every other file except mavs_ram refers to it by scoped names.
package mavs_pkg;

	localparam int WINDOW_MAX = 16;
	localparam int DATA_W     = 8;
	localparam int AW         = $clog2(WINDOW_MAX);
	localparam int SIZE_W     = $clog2(WINDOW_MAX + 1);
	localparam int TOTAL_W    = DATA_W + AW;
	localparam int CNT_W      = $clog2(TOTAL_W);
	localparam int IDX_W      = 2;

	localparam logic [IDX_W-1:0] REG_WINDOW_SIZE = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_STAB_THR    = IDX_W'(1);

	localparam logic OP_PUSH    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic [SIZE_W-1:0] WINDOW_SIZE_RST = SIZE_W'(16);
	localparam logic [DATA_W-1:0] STAB_THR_RST    = DATA_W'(5);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/mavs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Parameters set word width and depth; no package dependency.
module mavs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/mavs_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
// Uses mavs_pkg for widths and the status struct.
module mavs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mavs_pkg::TOTAL_W-1:0]  dividend,
	input  logic [mavs_pkg::SIZE_W-1:0]   divisor,
	output logic [mavs_pkg::DATA_W-1:0]   quotient,
	output mavs_pkg::div_stat_t           stat
);

	logic [mavs_pkg::SIZE_W-1:0]  rem_q;
	logic [mavs_pkg::TOTAL_W-1:0] dvd_q;
	logic [mavs_pkg::SIZE_W-1:0]  dsr_q;
	logic [mavs_pkg::CNT_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [mavs_pkg::SIZE_W:0]    rem_sh;
	logic [mavs_pkg::SIZE_W:0]    rem_sub;
	logic                         ge;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[mavs_pkg::TOTAL_W-1]};
		ge      = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[mavs_pkg::SIZE_W-1:0] : rem_sh[mavs_pkg::SIZE_W-1:0];
			dvd_q <= {dvd_q[mavs_pkg::TOTAL_W-2:0], ge};
			cnt_q <= cnt_q + mavs_pkg::CNT_W'(1);
			if (cnt_q == mavs_pkg::CNT_W'(mavs_pkg::TOTAL_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quotient  = dvd_q[mavs_pkg::DATA_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/moving_average_with_stability_top.sv
// Boxcar moving average over 8-bit samples with an adjacent-slot stability flag.
// Uses mavs_pkg, mavs_ram (sample ring) and mavs_div (mean division).
//
// Request channel (req_valid / req_stall) carries op and sample; a transfer
// happens when req_valid is high and req_stall is low. Op restart latches the
// clamped window size, empties the ring, zeroes the sum and arms the filter;
// it gives no response. Op push gives one response on rsp_valid / rsp_stall
// with average and stable.
// Before the first restart a push passes the sample through with stable low.
// Armed push: the ring slot is read, the sum updated and written back, then a
// scan reads slots 0 to N-1 through the single RAM read port while the divider
// produces one quotient bit a cycle over 12 steps, with N the window size; one
// item is in work at a time.
// A finished response waits in the output register while the next request is
// taken; it holds while rsp_stall is high.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 is window_size, index 1 the stability limit.
// Reset: filter disarmed, ring reads as zero, window size 16, threshold 5.
module moving_average_with_stability_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          op,
	input  logic [mavs_pkg::DATA_W-1:0]   sample,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [mavs_pkg::DATA_W-1:0]   average,
	output logic                          stable,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mavs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [mavs_pkg::DATA_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic                          armed_q;
	logic [mavs_pkg::SIZE_W-1:0]   size_q;
	logic [mavs_pkg::AW-1:0]       slot_q;
	logic [mavs_pkg::TOTAL_W-1:0]  total_q;
	logic [mavs_pkg::WINDOW_MAX-1:0] vld_q;
	logic [mavs_pkg::DATA_W-1:0]   sample_q;
	logic [mavs_pkg::AW-1:0]       scan_idx_q;
	logic                          rd_s1;
	logic [mavs_pkg::AW-1:0]       idx_s1;
	logic                          vld_s1;
	logic [mavs_pkg::DATA_W-1:0]   prev_q;
	logic [mavs_pkg::DATA_W-1:0]   worst_q;
	logic [mavs_pkg::DATA_W-1:0]   res_avg_q;
	logic                          chk_q;
	logic                          rsp_valid_q;
	logic [mavs_pkg::DATA_W-1:0]   average_q;
	logic                          stable_q;
	logic [mavs_pkg::SIZE_W-1:0]   window_size_q;
	logic [mavs_pkg::DATA_W-1:0]   thr_q;

	logic                          req_xfer;
	logic                          out_free;
	logic [mavs_pkg::AW-1:0]       raddr;
	logic                          ram_we;
	logic [mavs_pkg::DATA_W-1:0]   rdata;
	logic [mavs_pkg::DATA_W-1:0]   rd_val;
	logic [mavs_pkg::DATA_W-1:0]   diff;
	logic [mavs_pkg::TOTAL_W-1:0]  total_nxt;
	logic [mavs_pkg::SIZE_W-1:0]   slot_inc;
	logic [mavs_pkg::SIZE_W-1:0]   size_clamp;
	logic [mavs_pkg::DATA_W-1:0]   quotient;
	mavs_pkg::div_stat_t           div_stat;

	assign req_stall = state_q != ST_IDLE;
	assign req_xfer  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		raddr     = (state_q == ST_SCAN) ? scan_idx_q : slot_q;
		ram_we    = state_q == ST_UPD;
		rd_val    = vld_s1 ? rdata : '0;
		diff      = (rd_val >= prev_q) ? rd_val - prev_q : prev_q - rd_val;
		total_nxt = total_q - mavs_pkg::TOTAL_W'(rd_val) + mavs_pkg::TOTAL_W'(sample_q);
		slot_inc  = {1'b0, slot_q} + mavs_pkg::SIZE_W'(1);
		if (window_size_q == '0) begin
			size_clamp = mavs_pkg::SIZE_W'(1);
		end else if (window_size_q > mavs_pkg::SIZE_W'(mavs_pkg::WINDOW_MAX)) begin
			size_clamp = mavs_pkg::SIZE_W'(mavs_pkg::WINDOW_MAX);
		end else begin
			size_clamp = window_size_q;
		end
	end

	mavs_ram #(
		.WIDTH(mavs_pkg::DATA_W),
		.DEPTH(mavs_pkg::WINDOW_MAX)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(sample_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	mavs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ram_we),
		.dividend(total_nxt),
		.divisor (size_q),
		.quotient(quotient),
		.stat    (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= mavs_pkg::WINDOW_SIZE_RST;
			thr_q         <= mavs_pkg::STAB_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mavs_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_data[mavs_pkg::SIZE_W-1:0];
				mavs_pkg::REG_STAB_THR:    thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			armed_q     <= 1'b0;
			size_q      <= '0;
			slot_q      <= '0;
			total_q     <= '0;
			vld_q       <= '0;
			sample_q    <= '0;
			scan_idx_q  <= '0;
			rd_s1       <= 1'b0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			prev_q      <= '0;
			worst_q     <= '0;
			res_avg_q   <= '0;
			chk_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			average_q   <= '0;
			stable_q    <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			rd_s1  <= state_q == ST_SCAN;
			idx_s1 <= scan_idx_q;
			vld_s1 <= vld_q[raddr];
			if (rd_s1) begin
				prev_q <= rd_val;
				if (idx_s1 != '0 && diff > worst_q) begin
					worst_q <= diff;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						sample_q <= sample;
						if (op == mavs_pkg::OP_RESTART) begin
							armed_q <= 1'b1;
							size_q  <= size_clamp;
							slot_q  <= '0;
							total_q <= '0;
							vld_q   <= '0;
						end else if (armed_q) begin
							state_q <= ST_UPD;
						end else begin
							res_avg_q <= sample;
							chk_q     <= 1'b0;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_UPD: begin
					total_q       <= total_nxt;
					vld_q[slot_q] <= 1'b1;
					slot_q        <= (slot_inc >= size_q) ? '0 : slot_inc[mavs_pkg::AW-1:0];
					scan_idx_q    <= '0;
					worst_q       <= '0;
					chk_q         <= 1'b1;
					state_q       <= ST_SCAN;
				end
				ST_SCAN: begin
					if ({1'b0, scan_idx_q} == size_q - mavs_pkg::SIZE_W'(1)) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + mavs_pkg::AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!rd_s1 && div_stat.done) begin
						res_avg_q <= quotient;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						average_q   <= res_avg_q;
						stable_q    <= chk_q && (worst_q < thr_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign average   = average_q;
	assign stable    = stable_q;

endmodule

FILE: rtl/mavs_chk.sv
// Port-level checker for the moving average with stability top level.
// Uses mavs_pkg for widths and op codes; bound to the top level below.
module mavs_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          op,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [mavs_pkg::DATA_W-1:0]   average,
	input logic                          stable,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(average) && $stable(stable))
		else $error("response payload changed while stalled");

	a_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && op == mavs_pkg::OP_PUSH |=> req_stall)
		else $error("push transfer not followed by busy");

	a_restart_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && op == mavs_pkg::OP_RESTART |=> !req_stall)
		else $error("restart left the request channel stalled");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

endmodule

bind moving_average_with_stability_top mavs_chk u_mavs_chk (.*);

FILE: sim/moving_average_with_stability_top_tb.sv
// Testbench for moving_average_with_stability_top: directed and random sample streams,
// register writes between phases, random idling and stalls on both channels.
// Depends on rtl/mavs_pkg.sv and the RTL of the block; the scoreboard predicts each response.
`timescale 1ns / 100ps

module moving_average_with_stability_top_tb;

	localparam logic [mavs_pkg::IDX_W-1:0] REG_SPARE_LO = mavs_pkg::IDX_W'(2);
	localparam logic [mavs_pkg::IDX_W-1:0] REG_SPARE_HI = mavs_pkg::IDX_W'(3);
	localparam int STREAM_ITEMS = 1200;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [mavs_pkg::DATA_W-1:0] average;
		logic                        stable;
	} mean_rec_t;

	class mavg_tracker;
		logic [mavs_pkg::DATA_W-1:0] ring [mavs_pkg::WINDOW_MAX];
		int unsigned                 slot;
		int unsigned                 total;
		int unsigned                 span;
		bit                          armed;
		logic [4:0]                  win_cfg;
		logic [mavs_pkg::DATA_W-1:0] thr_cfg;
		mean_rec_t                   pending[$];
		int                          errors;

		function new();
			foreach (ring[i])
				ring[i] = '0;
			slot = 0;
			total = 0;
			span = 0;
			armed = 0;
			win_cfg = 5'(mavs_pkg::WINDOW_SIZE_RST);
			thr_cfg = mavs_pkg::STAB_THR_RST;
			errors = 0;
		endfunction

		function void write_reg(logic [mavs_pkg::IDX_W-1:0] idx,
				logic [mavs_pkg::DATA_W-1:0] data);
			case (idx)
				mavs_pkg::REG_WINDOW_SIZE: win_cfg = data[4:0];
				mavs_pkg::REG_STAB_THR:    thr_cfg = data;
				default: ;
			endcase
		endfunction

		function void take_item(logic kind, logic [mavs_pkg::DATA_W-1:0] smp);
			mean_rec_t   rec;
			int unsigned worst;
			int unsigned d;
			if (kind == mavs_pkg::OP_RESTART) begin
				span = 32'(win_cfg);
				if (span == 0)
					span = 1;
				if (span > mavs_pkg::WINDOW_MAX)
					span = mavs_pkg::WINDOW_MAX;
				foreach (ring[i])
					ring[i] = '0;
				slot = 0;
				total = 0;
				armed = 1;
				return;
			end
			if (!armed) begin
				rec.average = smp;
				rec.stable = 1'b0;
				pending.push_back(rec);
				return;
			end
			if (slot >= span)
				slot = 0;
			total = total - 32'(ring[slot]) + 32'(smp);
			ring[slot] = smp;
			slot++;
			if (slot >= span)
				slot = 0;
			worst = 0;
			for (int i = 0; i + 1 < span; i++) begin
				d = (ring[i] > ring[i+1]) ? 32'(ring[i]) - 32'(ring[i+1])
					: 32'(ring[i+1]) - 32'(ring[i]);
				if (d > worst)
					worst = d;
			end
			rec.average = mavs_pkg::DATA_W'(total / span);
			rec.stable = (worst < 32'(thr_cfg));
			pending.push_back(rec);
		endfunction

		function void check_output(logic [mavs_pkg::DATA_W-1:0] avg, logic stab);
			mean_rec_t rec;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response average %0d stable %0d", $time, avg, stab);
				errors++;
				return;
			end
			rec = pending.pop_front();
			if (avg !== rec.average) begin
				$display("%0t: average expected %0d actual %0d", $time, rec.average, avg);
				errors++;
			end
			if (stab !== rec.stable) begin
				$display("%0t: stable expected %0d actual %0d", $time, rec.stable, stab);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	logic                          op;
	logic [mavs_pkg::DATA_W-1:0]   sample;
	logic                          rsp_valid;
	logic                          rsp_stall;
	logic [mavs_pkg::DATA_W-1:0]   average;
	logic                          stable;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [mavs_pkg::IDX_W-1:0]    cfg_index;
	logic [mavs_pkg::DATA_W-1:0]   cfg_data;

	mavg_tracker tracker;
	bit          src_idle;
	bit          snk_idle;
	int          hold_cycles;
	int          items_sent;

	moving_average_with_stability_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (op),
		.sample    (sample),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.average   (average),
		.stable    (stable),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial
		clk = 1'b0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
			if (req_valid && !req_stall)
				tracker.take_item(op, sample);
			if (rsp_valid && !rsp_stall)
				tracker.check_output(average, stable);
		end
	end

	initial begin : sink
		int pause;
		rsp_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				pause = hold_cycles;
				hold_cycles = 0;
			end else begin
				pause = snk_idle ? $urandom_range(0, 5) : 0;
			end
			if (pause > 0) begin
				rsp_stall <= 1'b1;
				repeat (pause) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	initial begin
		#20_000_000;
		$display("moving_average_with_stability_top_tb: done, errors");
		$finish;
	end

	task automatic send_item(input logic kind, input logic [mavs_pkg::DATA_W-1:0] smp);
		int gap;
		gap = src_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		op <= kind;
		sample <= smp;
		do @(posedge clk); while (!(req_valid && !req_stall));
		items_sent++;
	endtask

	task automatic push(input logic [mavs_pkg::DATA_W-1:0] smp);
		send_item(mavs_pkg::OP_PUSH, smp);
	endtask

	task automatic restart();
		send_item(mavs_pkg::OP_RESTART, mavs_pkg::DATA_W'($urandom_range(0, 255)));
	endtask

	// drop valid, wait for every response, then let a restart settle
	task automatic wait_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mavs_pkg::IDX_W-1:0] idx,
			input logic [mavs_pkg::DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [mavs_pkg::DATA_W-1:0] win,
			input logic [mavs_pkg::DATA_W-1:0] thr);
		write_reg(mavs_pkg::REG_WINDOW_SIZE, win);
		write_reg(mavs_pkg::REG_STAB_THR, thr);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_stream(input int count);
		int lvl;
		int roll;
		lvl = $urandom_range(0, 255);
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				restart();
			end else if (roll < 14) begin
				push(mavs_pkg::DATA_W'($urandom_range(0, 255)));
			end else begin
				lvl += int'($urandom_range(0, 6)) - 3;
				if (lvl < 0)
					lvl = 0;
				if (lvl > 255)
					lvl = 255;
				push(mavs_pkg::DATA_W'(lvl));
			end
		end
	endtask

	initial begin
		int  phase;
		int  pick;
		logic [mavs_pkg::DATA_W-1:0] win;
		logic [mavs_pkg::DATA_W-1:0] thr;
		tracker = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		op <= mavs_pkg::OP_PUSH;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= mavs_pkg::REG_WINDOW_SIZE;
		cfg_data <= '0;
		src_idle = 1;
		snk_idle = 1;
		hold_cycles = 0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through before arming, then defaults
		write_reg(REG_SPARE_LO, 8'hFF);
		write_reg(REG_SPARE_HI, 8'h5A);
		cfg_valid <= 1'b0;
		push(8'h00);
		push(8'hFF);
		push(8'hA5);
		restart();
		push(8'h00);
		push(8'h02);
		push(8'hFF);
		push(8'hFF);
		push(8'h5A);
		wait_drain();

		// window clamped to one, threshold zero then one
		configure(8'h00, 8'h00);
		restart();
		push(8'hFF);
		push(8'h00);
		wait_drain();
		write_reg(mavs_pkg::REG_STAB_THR, 8'h01);
		cfg_valid <= 1'b0;
		push(8'h81);
		push(8'h7E);
		wait_drain();

		// oversized window clamps to the maximum; a new size waits for restart
		configure(8'hFF, 8'hFF);
		restart();
		push(8'h10);
		push(8'h11);
		push(8'h12);
		push(8'h13);
		push(8'h14);
		wait_drain();
		write_reg(mavs_pkg::REG_WINDOW_SIZE, 8'h04);
		cfg_valid <= 1'b0;
		push(8'h20);
		wait_drain();
		restart();
		push(8'h40);
		push(8'h41);
		wait_drain();

		phase = 0;
		while (items_sent < STREAM_ITEMS) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0:       win = 8'h00;
				1:       win = 8'h01;
				2:       win = 8'h10;
				3:       win = 8'hFF;
				4, 5, 6: win = mavs_pkg::DATA_W'($urandom_range(1, 16));
				default: win = mavs_pkg::DATA_W'($urandom_range(0, 255));
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0:       thr = 8'h00;
				1:       thr = 8'hFF;
				2, 3:    thr = mavs_pkg::DATA_W'($urandom_range(0, 255));
				default: thr = mavs_pkg::DATA_W'($urandom_range(1, 40));
			endcase
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					mavs_pkg::DATA_W'($urandom_range(0, 255)));
			configure(win, thr);
			src_idle = $urandom_range(0, 3) != 0;
			snk_idle = $urandom_range(0, 3) != 0;
			if (phase == 2 || phase == 9)
				hold_cycles = LONG_HOLD;
			if ($urandom_range(0, 9) != 0)
				restart();
			run_stream($urandom_range(10, 60));
			wait_drain();
			phase++;
		end

		if (tracker.errors == 0)
			$display("moving_average_with_stability_top_tb: done, clean");
		else
			$display("moving_average_with_stability_top_tb: done, errors");
		$finish;
	end

endmodule
